[hdl/i2cbb_pkg.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master package
// Operation and command codes, the sequencer state record and the result
// record that the phase logic and the top level share.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ADDR  = 3'd5;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // First phase after the bits of a write byte, and the sample that completes a read byte.
  localparam logic [4:0] WR_BITS_END  = 5'd24;
  localparam logic [4:0] RD_LAST_SAMP = 5'd23;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [6:0] slave_address;
    logic       read_not_write;
    logic       stop_after;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    op_e        op;
    logic [4:0] phase;
    logic [7:0] shift;
    logic       ack;
    logic       stop;
    logic [7:0] held;
  } state_t;

  localparam state_t STATE_RESET = '{
    scl:   1'b1,
    sda:   1'b1,
    op:    OP_IDLE,
    phase: 5'd0,
    shift: 8'd0,
    ack:   1'b0,
    stop:  1'b0,
    held:  8'd0
  };

  // Remainder of a phase number by three, as a small table.
  function automatic logic [1:0] mod3(input logic [4:0] p);
    logic [1:0] r;
    case (p) inside
      5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27, 5'd30:
        r = 2'd0;
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28, 5'd31:
        r = 2'd1;
      default:
        r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

[hdl/i2cbb_if.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master channels
// Valid/ready channels for command requests and for result requests.
// ----------------------------------------------------------------------------
interface i2cbb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;
  logic [6:0] slave_address;
  logic       read_not_write;
  logic       stop_after;
  logic       sda_sample;

  modport source (
    output valid, cmd, data_byte, slave_address, read_not_write, stop_after,
           sda_sample,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_byte, slave_address, read_not_write, stop_after,
           sda_sample,
    output ready
  );
endinterface

interface i2cbb_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic       acked;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (
    output valid, scl_level, sda_level, busy_res, done_res, acked, read_byte,
           rejected,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, busy_res, done_res, acked, read_byte,
           rejected,
    output ready
  );
endinterface

[hdl/i2c_bit_bang_master.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang master
// Path: an accepted request waits in the input register; the phase logic
// between the input register and the result register then forms its result.
// Throughput: one request per cycle unless res_o.ready stalls the result side.
// Reset: asynchronous, active low; both pins released, sequencer idle,
// acknowledge and read byte cleared, both pipeline registers empty.
// ----------------------------------------------------------------------------
module i2c_bit_bang_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbb_cmd_if.sink   cmd_i,
  i2cbb_res_if.source res_o
);
  import i2cbb_pkg::*;

  logic   in_valid_q;
  cmd_t   in_item_q;
  logic   out_valid_q;
  res_t   out_res_q;
  state_t st_q;
  state_t st_d;
  res_t   res_d;
  logic   out_free;
  logic   advance;
  logic   take;

  assign out_free    = ~out_valid_q | res_o.ready;
  assign advance     = in_valid_q & out_free;
  assign cmd_i.ready = ~in_valid_q | out_free;
  assign take        = cmd_i.valid & cmd_i.ready;

  i2cbb_phase u_phase (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_item_q.cmd            <= cmd_i.cmd;
      in_item_q.data_byte      <= cmd_i.data_byte;
      in_item_q.slave_address  <= cmd_i.slave_address;
      in_item_q.read_not_write <= cmd_i.read_not_write;
      in_item_q.stop_after     <= cmd_i.stop_after;
      in_item_q.sda_sample     <= cmd_i.sda_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = out_res_q.scl_level;
  assign res_o.sda_level = out_res_q.sda_level;
  assign res_o.busy_res  = out_res_q.busy_res;
  assign res_o.done_res  = out_res_q.done_res;
  assign res_o.acked     = out_res_q.acked;
  assign res_o.read_byte = out_res_q.read_byte;
  assign res_o.rejected  = out_res_q.rejected;

  // An idle sequencer always sits at phase zero.
  a_idle_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.op == OP_IDLE) |-> (st_q.phase == 5'd0))
    else $error("idle sequencer with nonzero phase");

  // A start sequence never runs past its fourth phase.
  a_start_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.op == OP_START) |-> (st_q.phase <= 5'd3))
    else $error("start sequence overran");

  // A finished sequence is never also a rejected command, and leaves idle.
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.done_res) |-> (!out_res_q.rejected && !out_res_q.busy_res))
    else $error("done result inconsistent");

  // A held request in the input register stays until the result side frees.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(st_q)))
    else $error("input stage lost a stalled request");

endmodule

[hdl/i2cbb_phase.sv]
// ----------------------------------------------------------------------------
// I2C bit-bang phase logic
// Applies one request to the state: loads a command sequence (rejected
// while busy) or does one pin phase on a tick, and forms the result record.
// ----------------------------------------------------------------------------
module i2cbb_phase (
  input  i2cbb_pkg::state_t st_i,
  input  i2cbb_pkg::cmd_t   item_i,
  output i2cbb_pkg::state_t st_o,
  output i2cbb_pkg::res_t   res_o
);
  import i2cbb_pkg::*;

  state_t     nx;
  logic       fin;
  logic       done;
  logic       rej;
  logic [1:0] wsub;
  logic [1:0] rsub;
  logic [4:0] p;

  assign p    = st_i.phase;
  assign wsub = mod3(p);
  // Read bit phases start one phase later, so their remainder is of p - 1.
  assign rsub = mod3(p - 5'd1);

  always_comb begin
    nx   = st_i;
    fin  = 1'b0;
    done = 1'b0;
    rej  = 1'b0;
    if (item_i.cmd == CMD_TICK) begin
      case (st_i.op)
        OP_START: begin
          case (p)
            5'd0:    nx.sda = 1'b1;
            5'd1:    nx.scl = 1'b1;
            5'd2:    nx.sda = 1'b0;
            default: begin
              nx.scl = 1'b0;
              fin    = 1'b1;
            end
          endcase
        end
        OP_STOP: begin
          case (p)
            5'd0:    nx.sda = 1'b0;
            5'd1:    nx.scl = 1'b1;
            default: begin
              nx.sda = 1'b1;
              fin    = 1'b1;
            end
          endcase
        end
        OP_WRITE: begin
          if (p < WR_BITS_END) begin
            case (wsub)
              2'd0:    nx.sda = ((st_i.shift & MSB_MASK) != 8'd0);
              2'd1:    nx.scl = 1'b1;
              default: begin
                nx.scl   = 1'b0;
                nx.shift = {st_i.shift[6:0], 1'b0};
              end
            endcase
          end else begin
            case (p)
              5'd24:   nx.sda = 1'b1;
              5'd25:   nx.scl = 1'b1;
              5'd26:   nx.ack = ~item_i.sda_sample;
              default: begin
                nx.scl = 1'b0;
                fin    = 1'b1;
              end
            endcase
          end
        end
        OP_READ: begin
          if (p == 5'd0) begin
            nx.sda = 1'b1;
          end else if (p <= WR_BITS_END) begin
            case (rsub)
              2'd0: nx.scl = 1'b1;
              2'd1: begin
                nx.shift = {st_i.shift[6:0], item_i.sda_sample};
                if (p == RD_LAST_SAMP) begin
                  nx.held = {st_i.shift[6:0], item_i.sda_sample};
                end
              end
              default: nx.scl = 1'b0;
            endcase
          end else begin
            case (p)
              5'd25: nx.sda = st_i.stop;
              5'd26: nx.scl = 1'b1;
              5'd27: begin
                nx.scl = 1'b0;
                fin    = ~st_i.stop;
              end
              5'd28: nx.sda = 1'b0;
              5'd29: nx.scl = 1'b1;
              default: begin
                nx.sda = 1'b1;
                fin    = 1'b1;
              end
            endcase
          end
        end
        default: fin = 1'b0;
      endcase
      if (st_i.op != OP_IDLE) begin
        if (fin) begin
          nx.op    = OP_IDLE;
          nx.phase = 5'd0;
          done     = 1'b1;
        end else begin
          nx.phase = p + 5'd1;
        end
      end
    end else if (item_i.cmd <= CMD_ADDR) begin
      if (st_i.op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        nx.phase = 5'd0;
        case (item_i.cmd)
          CMD_START: nx.op = OP_START;
          CMD_STOP:  nx.op = OP_STOP;
          CMD_WRITE: begin
            nx.op    = OP_WRITE;
            nx.shift = item_i.data_byte;
          end
          CMD_READ: begin
            nx.op    = OP_READ;
            nx.shift = 8'd0;
            nx.stop  = item_i.stop_after;
          end
          default: begin
            nx.op    = OP_WRITE;
            nx.shift = {item_i.slave_address, item_i.read_not_write};
          end
        endcase
      end
    end
  end

  assign st_o = nx;

  always_comb begin
    res_o.scl_level = nx.scl;
    res_o.sda_level = nx.sda;
    res_o.busy_res  = (nx.op != OP_IDLE);
    res_o.done_res  = done;
    res_o.acked     = nx.ack;
    res_o.read_byte = nx.held;
    res_o.rejected  = rej;
  end

endmodule
